### src/rvde_pkg.sv
// ----------------------------------------------------------------------------
// rvde_pkg
// shared opcodes, function codes and item types of the rv32i decode/execute
// ----------------------------------------------------------------------------
package rvde_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    localparam logic [6:0] F7_ALT     = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 112;

    typedef struct packed {
        logic [31:0] rs2_value;
        logic [31:0] rs1_value;
        logic [31:0] pc_value;
        logic [31:0] instr_word;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  opcode;
        logic [4:0]  rd;
        logic [2:0]  funct3;
        logic        alt;
        logic [31:0] imm;
    } dec_t;

    typedef struct packed {
        logic [31:0] redirect_target;
        logic        redirect;
        logic [31:0] store_value;
        logic [2:0]  access_code;
        logic [1:0]  mem_access;
        logic [31:0] result_value;
        logic        wr_en;
        logic [4:0]  dest_reg;
    } out_item_t;

endpackage

### src/rvde_decode.sv
// ----------------------------------------------------------------------------
// rvde_decode
// field split and i/s/b/u/j immediate generation
// ----------------------------------------------------------------------------
module rvde_decode (
    input  logic [31:0]    instr_word,
    output rvde_pkg::dec_t dec
);
    import rvde_pkg::*;

    logic [6:0]  opcode;
    logic [31:0] imm;

    assign opcode = instr_word[6:0];

    always_comb begin
        case (opcode)
            OPC_IMM, OPC_LOAD, OPC_JALR: begin
                imm = {{20{instr_word[31]}}, instr_word[31:20]};
            end
            OPC_STORE: begin
                imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
            end
            OPC_BRANCH: begin
                imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                       instr_word[30:25], instr_word[11:8], 1'b0};
            end
            OPC_LUI, OPC_AUIPC: begin
                imm = {instr_word[31:12], 12'd0};
            end
            OPC_JAL: begin
                imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                       instr_word[20], instr_word[30:21], 1'b0};
            end
            default: begin
                imm = 32'd0;
            end
        endcase
    end

    always_comb begin
        dec.opcode = opcode;
        dec.funct3 = instr_word[14:12];
        dec.imm    = imm;
        dec.rd     = ((opcode == OPC_STORE) || (opcode == OPC_BRANCH)) ?
                     5'd0 : instr_word[11:7];
        // register ops use the whole funct7, immediate shifts only bit 30
        if (opcode == OPC_REG) begin
            dec.alt = (instr_word[31:25] == F7_ALT);
        end else begin
            dec.alt = instr_word[30];
        end
    end

endmodule

### src/rvde_execute.sv
// ----------------------------------------------------------------------------
// rvde_execute
// alu, branch compare, jump and address generation for one decoded item
// ----------------------------------------------------------------------------
module rvde_execute (
    input  logic [31:0]         pc_value,
    input  logic [31:0]         rs1_value,
    input  logic [31:0]         rs2_value,
    input  rvde_pkg::dec_t      dec,
    output rvde_pkg::out_item_t res
);
    import rvde_pkg::*;

    logic [31:0] op_b;
    logic [4:0]  shamt;
    logic [31:0] alu_out;
    logic [31:0] addr_sum;
    logic [31:0] pc_sum;
    logic [31:0] link;
    logic        lt_s;
    logic        lt_u;
    logic        eq;
    logic        taken;
    logic [31:0] result;
    logic [1:0]  acc;
    logic        red;
    logic [31:0] tgt;

    assign op_b     = ((dec.opcode == OPC_REG) || (dec.opcode == OPC_BRANCH)) ?
                      rs2_value : dec.imm;
    assign shamt    = op_b[4:0];
    assign addr_sum = rs1_value + dec.imm;
    assign pc_sum   = pc_value + dec.imm;
    assign link     = pc_value + 32'd4;
    assign lt_s     = ($signed(rs1_value) < $signed(op_b));
    assign lt_u     = (rs1_value < op_b);
    assign eq       = (rs1_value == op_b);

    always_comb begin
        case (dec.funct3)
            F3_ADD: begin
                if ((dec.opcode == OPC_REG) && dec.alt) begin
                    alu_out = rs1_value - op_b;
                end else begin
                    alu_out = rs1_value + op_b;
                end
            end
            F3_SLL:  alu_out = rs1_value << shamt;
            F3_SLT:  alu_out = {31'd0, lt_s};
            F3_SLTU: alu_out = {31'd0, lt_u};
            F3_XOR:  alu_out = rs1_value ^ op_b;
            F3_SR: begin
                if (dec.alt) begin
                    alu_out = $unsigned($signed(rs1_value) >>> shamt);
                end else begin
                    alu_out = rs1_value >> shamt;
                end
            end
            F3_OR:   alu_out = rs1_value | op_b;
            default: alu_out = rs1_value & op_b;
        endcase
    end

    always_comb begin
        case (dec.funct3)
            F3_BEQ:  taken = eq;
            F3_BNE:  taken = !eq;
            F3_BLT:  taken = lt_s;
            F3_BGE:  taken = !lt_s;
            F3_BLTU: taken = lt_u;
            F3_BGEU: taken = !lt_u;
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        result = 32'd0;
        acc    = MEM_NONE;
        red    = 1'b0;
        tgt    = 32'd0;
        case (dec.opcode)
            OPC_REG, OPC_IMM: begin
                result = alu_out;
            end
            OPC_LOAD: begin
                result = addr_sum;
                acc    = MEM_LOAD;
            end
            OPC_STORE: begin
                result = addr_sum;
                acc    = MEM_STORE;
            end
            OPC_BRANCH: begin
                red = taken;
                tgt = taken ? pc_sum : 32'd0;
            end
            OPC_JAL: begin
                result = link;
                red    = 1'b1;
                tgt    = pc_sum;
            end
            OPC_JALR: begin
                result = link;
                red    = 1'b1;
                tgt    = {addr_sum[31:1], 1'b0};
            end
            OPC_LUI: begin
                result = dec.imm;
            end
            OPC_AUIPC: begin
                result = pc_sum;
            end
            default: begin
                result = 32'd0;
            end
        endcase
    end

    always_comb begin
        res.dest_reg        = dec.rd;
        res.wr_en           = (dec.rd != 5'd0);
        res.result_value    = result;
        res.mem_access      = acc;
        res.access_code     = dec.funct3;
        res.store_value     = rs2_value;
        res.redirect        = red;
        res.redirect_target = tgt;
    end

endmodule

### src/rv32i_decode_execute_core.sv
// result path: an accepted item is held in the input register, then decoded and
//   executed into the result register; a full result register stalls it
// throughput: one item per cycle, set by the input register and result register
//   pair; s_tready falls only when both registers are full and m_tready is low
// reset: synchronous active-low aresetn empties both registers
// ----------------------------------------------------------------------------
// rv32i_decode_execute_core
// registered rv32i decode and execute unit with stream input and output
// ----------------------------------------------------------------------------
module rv32i_decode_execute_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // instr_word, pc_value, rs1_value, rs2_value
    input  logic [rvde_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // dest_reg, wr_en, result_value, mem_access, access_code,
    // store_value, redirect, redirect_target, zero pad
    output logic [rvde_pkg::M_TDATA_W-1:0] m_tdata
);
    import rvde_pkg::*;

    in_item_t  in_reg;
    in_item_t  in_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      out_ready;
    logic      s_accept;
    dec_t      dec;
    out_item_t res;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    rvde_decode u_decode (
        .instr_word (in_reg.instr_word),
        .dec        (dec)
    );

    rvde_execute u_execute (
        .pc_value  (in_reg.pc_value),
        .rs1_value (in_reg.rs1_value),
        .rs2_value (in_reg.rs2_value),
        .dec       (dec),
        .res       (res)
    );

    always_comb begin
        in_next        = s_accept ? in_item_t'(s_tdata) : in_reg;
        in_valid_next  = s_tready ? s_accept : in_valid_reg;
        out_next       = (out_ready && in_valid_reg) ? res : out_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(out_item_t)){1'b0}}, out_reg};

endmodule

### src/rvde_checker.sv
// ----------------------------------------------------------------------------
// rvde_checker
// port-level checks of the rv32i decode/execute core
// ----------------------------------------------------------------------------
module rvde_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rvde_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rvde_pkg::M_TDATA_W-1:0] m_tdata
);
    import rvde_pkg::*;

    // stalled input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while stalled");

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // no redirect means a zero target
    a_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[75] |-> (m_tdata[107:76] == 32'd0))
        else $error("target set without redirect");

    // stores never write a register or redirect
    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[39:38] == MEM_STORE) |-> !m_tdata[5] && !m_tdata[75])
        else $error("store item writes a register or redirects");

endmodule

bind rv32i_decode_execute_core rvde_checker u_rvde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/rv32i_decode_execute_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i_decode_execute_core_tb
// self-checking bench: every accepted instruction is run through a local
// decode/execute predictor, and each result item is compared field by field
// in order, under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module rv32i_decode_execute_core_tb;

    import rvde_pkg::*;

    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_CUSTOM = 7'h0B;
    localparam int         WATCHDOG_LIMIT = 1000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    out_item_t expected_q[$];
    out_item_t exp_item;
    out_item_t got_item;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;

    rv32i_decode_execute_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic alt,
                                             input logic is_reg, input logic [31:0] a,
                                             input logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            F3_ADD:  return (is_reg && alt) ? a - b : a + b;
            F3_SLL:  return a << sh;
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> sh) : a >> sh;
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic out_item_t execute_instr(input in_item_t it);
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic        taken;
        out_item_t   r;
        w = it.instr_word;
        a = it.rs1_value;
        b = it.rs2_value;
        opc = w[6:0];
        f3 = w[14:12];
        taken = 1'b0;
        r = '0;
        case (opc)
            OPC_IMM, OPC_LOAD, OPC_JALR: imm = {{20{w[31]}}, w[31:20]};
            OPC_STORE:  imm = {{20{w[31]}}, w[31:25], w[11:7]};
            OPC_BRANCH: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            OPC_LUI, OPC_AUIPC: imm = {w[31:12], 12'd0};
            OPC_JAL:    imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:    imm = '0;
        endcase
        r.dest_reg = (opc == OPC_STORE || opc == OPC_BRANCH) ? 5'd0 : w[11:7];
        r.access_code = f3;
        r.store_value = b;
        r.mem_access = MEM_NONE;
        case (opc)
            OPC_REG: r.result_value = alu_calc(f3, w[31:25] == F7_ALT, 1'b1, a, b);
            OPC_IMM: r.result_value = alu_calc(f3, imm[10], 1'b0, a, imm);
            OPC_LOAD: begin
                r.result_value = a + imm;
                r.mem_access = MEM_LOAD;
            end
            OPC_STORE: begin
                r.result_value = a + imm;
                r.mem_access = MEM_STORE;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  taken = (a == b);
                    F3_BNE:  taken = (a != b);
                    F3_BLT:  taken = ($signed(a) < $signed(b));
                    F3_BGE:  taken = !($signed(a) < $signed(b));
                    F3_BLTU: taken = (a < b);
                    F3_BGEU: taken = (a >= b);
                    default: taken = 1'b0;
                endcase
                if (taken) begin
                    r.redirect = 1'b1;
                    r.redirect_target = it.pc_value + imm;
                end
            end
            OPC_JAL: begin
                r.result_value = it.pc_value + 32'd4;
                r.redirect = 1'b1;
                r.redirect_target = it.pc_value + imm;
            end
            OPC_JALR: begin
                r.result_value = it.pc_value + 32'd4;
                r.redirect = 1'b1;
                r.redirect_target = (a + imm) & ~32'd1;
            end
            OPC_LUI:   r.result_value = imm;
            OPC_AUIPC: r.result_value = it.pc_value + imm;
            default:   r.result_value = '0;
        endcase
        r.wr_en = (r.dest_reg != 5'd0) && (r.mem_access != MEM_STORE);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    // input/result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_q.push_back(execute_instr(in_item_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got_item = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
                if (expected_q.size() == 0) begin
                    $error("result item with no instruction pending");
                    error_count++;
                end else begin
                    exp_item = expected_q.pop_front();
                    check_field("dest_reg", 32'(exp_item.dest_reg),
                                32'(got_item.dest_reg));
                    check_field("wr_en", 32'(exp_item.wr_en), 32'(got_item.wr_en));
                    check_field("result_value", exp_item.result_value,
                                got_item.result_value);
                    check_field("mem_access", 32'(exp_item.mem_access),
                                32'(got_item.mem_access));
                    check_field("access_code", 32'(exp_item.access_code),
                                32'(got_item.access_code));
                    check_field("store_value", exp_item.store_value, got_item.store_value);
                    check_field("redirect", 32'(exp_item.redirect),
                                32'(got_item.redirect));
                    check_field("redirect_target", exp_item.redirect_target,
                                got_item.redirect_target);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("rv32i_decode_execute_core_tb: errors");
                $finish;
            end
        end
    end

    // sink stalls in bursts of random length, started only while idle_on is set
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic send_instr(input logic [31:0] word, input logic [31:0] pc,
                              input logic [31:0] rs1, input logic [31:0] rs2);
        in_item_t item;
        item.instr_word = word;
        item.pc_value = pc;
        item.rs1_value = rs1;
        item.rs2_value = rs2;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tdata = item;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {f7, 5'd7, 5'd3, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {imm, 5'd3, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [2:0] f3);
        return {imm[11:5], 5'd7, 5'd3, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [2:0] f3);
        return {imm[12], imm[10:5], 5'd7, 5'd3, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rd, opc};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 40));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] word;
        logic [31:0] pc;
        logic [31:0] rs1;
        logic [31:0] rs2;
        word = $urandom;
        case ($urandom_range(0, 13))
            0:       word[6:0] = OPC_LOAD;
            1:       word[6:0] = OPC_STORE;
            2, 3:    word[6:0] = OPC_BRANCH;
            4, 5:    word[6:0] = OPC_REG;
            6, 7:    word[6:0] = OPC_IMM;
            8:       word[6:0] = OPC_JAL;
            9:       word[6:0] = OPC_JALR;
            10:      word[6:0] = OPC_LUI;
            11:      word[6:0] = OPC_AUIPC;
            12:      word[6:0] = OPC_SYSTEM;
            default: word[6:0] = 7'($urandom);
        endcase
        if (word[6:0] == OPC_REG && $urandom_range(0, 3) != 0)
            word[31:25] = $urandom_range(0, 1) ? F7_ALT : 7'h00;
        pc = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFC : $urandom;
        rs1 = pick_operand();
        rs2 = ($urandom_range(0, 3) == 0) ? rs1 : pick_operand();
        send_instr(word, pc, rs1, rs2);
    endtask

    task automatic test_alu_reg();
        send_instr(enc_r(7'h01, F3_ADD, 5'd1, OPC_REG), 32'h0, 32'hFFFF_FFFF, 32'h1);
        send_instr(enc_r(F7_ALT, F3_ADD, 5'd2, OPC_REG), 32'h4, 32'h0, 32'h1);
        send_instr(enc_r(F7_ALT, F3_SR, 5'd3, OPC_REG), 32'h8, 32'h8000_0000, 32'h1F);
        send_instr(enc_r(7'h7F, F3_SR, 5'd4, OPC_REG), 32'hC, 32'h8000_0000, 32'h3F);
        send_instr(enc_r(7'h00, F3_SLT, 5'd31, OPC_REG), 32'h10, 32'h8000_0000,
                   32'h7FFF_FFFF);
    endtask

    task automatic test_alu_imm();
        send_instr(enc_i(12'h800, F3_ADD, 5'd5, OPC_IMM), 32'h14, 32'h0, 32'h0);
        send_instr(enc_i(12'h41F, F3_SR, 5'd6, OPC_IMM), 32'h18, 32'hF000_0000, 32'h0);
        send_instr(enc_i(12'h01F, F3_SR, 5'd7, OPC_IMM), 32'h1C, 32'hF000_0000, 32'h0);
    endtask

    task automatic test_load_store();
        send_instr(enc_i(12'h7FF, 3'd2, 5'd8, OPC_LOAD), 32'h20, 32'hFFFF_F800, 32'h5);
        send_instr(enc_s(12'h800, 3'd0), 32'h24, 32'h0000_0100, 32'hDEAD_BEEF);
    endtask

    task automatic test_branches();
        for (int f3 = 0; f3 < 8; f3++)
            send_instr(enc_b(13'h1FFE, 3'(f3)), 32'h100, 32'h8000_0000, 32'h1);
    endtask

    task automatic test_jumps();
        send_instr(enc_j(21'h10_0000, 5'd1), 32'h0000_0010, 32'h0, 32'h0);
        send_instr(enc_j(21'h0F_FFFE, 5'd0), 32'hFFFF_FFFC, 32'h0, 32'h0);
        send_instr(enc_i(12'h001, 3'd0, 5'd1, OPC_JALR), 32'h40, 32'h0000_1000, 32'h0);
    endtask

    task automatic test_upper();
        send_instr(enc_u(20'hFFFFF, 5'd31, OPC_LUI), 32'h44, 32'h0, 32'h0);
        send_instr(enc_u(20'h00001, 5'd9, OPC_AUIPC), 32'hFFFF_F800, 32'h0, 32'h0);
    endtask

    task automatic test_unknown_opcode();
        send_instr(enc_i(12'h000, 3'd0, 5'd10, OPC_SYSTEM), 32'h48, 32'h1, 32'h2);
        send_instr(enc_i(12'hFFF, 3'd7, 5'd11, OPC_CUSTOM), 32'h4C, 32'h3, 32'h4);
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 11; blk++) begin
            idle_on = (blk % 3) != 2;
            repeat (150) send_random();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (275) send_random();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_alu_reg();
        test_alu_imm();
        test_load_store();
        test_branches();
        test_jumps();
        test_upper();
        test_unknown_opcode();
        test_random_mix();
        test_back_to_back();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (error_count == 0)
            $display("rv32i_decode_execute_core_tb: clean");
        else
            $display("rv32i_decode_execute_core_tb: errors");
        $finish;
    end

endmodule
